>>> rtl/tlspq_pkg.sv
package tlspq_pkg;

  localparam int unsigned TLSPQ_DEPTH = 16;

  localparam int unsigned PRI_W      = 2;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [LIMIT_W-1:0] STALE_LIMIT_RST = 16'd10;

  localparam logic [PRI_W-1:0] PRI_EMPTY = 2'd0;
  localparam logic [PRI_W-1:0] PRI_LOW   = 2'd1;
  localparam logic [PRI_W-1:0] PRI_MID   = 2'd2;
  localparam logic [PRI_W-1:0] PRI_HIGH  = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [PRI_W-1:0]   pri;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  typedef struct packed {
    logic               pop;
    logic               push_low;
    logic               push_mid;
    logic               push_high;
    logic [STAMP_W-1:0] stamp;
  } cell_op_t;

endpackage

>>> rtl/three_level_shift_priority_queue_unit.sv
// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid / in_tready  in_tuser: command; in_tdata: priority, stamp
// out_      master     out_tvalid/out_tready  out_tdata: head priority, head stamp, overdue
// cfg_      slave      cfg_valid / cfg_ready  cfg_data: stale limit
//
// One transaction is accepted per cycle while in_tready is high; its result is
// registered and appears in the cycle after acceptance. Every queue slot is a
// cell that updates from its neighbors, so the rate does not depend on queue depth.
// A result waiting in the output register blocks input only if out_tready is low.
// Synchronous reset empties the queue and sets the stale limit to 10.
module three_level_shift_priority_queue_unit
  import tlspq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = TLSPQ_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // priority_req[1:0], stamp[33:2], zero fill
  input  logic [CMD_W-1:0]      in_tuser,   // command[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // head_priority[1:0], head_stamp[33:2],
                                            // overdue[34], zero fill
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_W-1:0]    cfg_data
);

  logic                  in_fire;
  cmd_t                  cmd;
  logic [PRI_W-1:0]      req_pri;
  logic [STAMP_W-1:0]    req_stamp;
  cell_op_t              op;
  slot_t                 slots [QUEUE_DEPTH];
  slot_t                 head_entry;
  logic [STAMP_W:0]      age;
  logic                  overdue;
  logic [OUT_DATA_W-1:0] result;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [LIMIT_W-1:0]    limit_r;

  assign cmd       = cmd_t'(in_tuser);
  assign req_pri   = in_tdata[PRI_W-1:0];
  assign req_stamp = in_tdata[PRI_W+STAMP_W-1:PRI_W];
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    op.pop       = 1'b0;
    op.push_low  = 1'b0;
    op.push_mid  = 1'b0;
    op.push_high = 1'b0;
    op.stamp     = req_stamp;
    if (in_fire) begin
      unique case (cmd)
        CMD_PUSH: begin
          op.push_low  = (req_pri == PRI_LOW);
          op.push_mid  = (req_pri == PRI_MID);
          op.push_high = (req_pri == PRI_HIGH);
        end
        CMD_POP:   op.pop = 1'b1;
        CMD_CHECK: ;
        default:   ;
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t left_i;
    slot_t right_i;
    if (i == 0) begin : g_head
      assign left_i.pri   = PRI_HIGH;
      assign left_i.stamp = req_stamp;
    end else begin : g_body
      assign left_i = slots[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_i = '0;
    end else begin : g_inner
      assign right_i = slots[i+1];
    end
    tlspq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .op    (op),
      .left  (left_i),
      .right (right_i),
      .slot  (slots[i])
    );
  end

  assign head_entry = slots[0];
  assign age        = {1'b0, req_stamp} - {1'b0, head_entry.stamp};
  assign overdue    = (head_entry.pri != PRI_EMPTY) && !age[STAMP_W]
                      && (age[STAMP_W-1:0] > {{(STAMP_W-LIMIT_W){1'b0}}, limit_r});

  always_comb begin
    result = '0;
    unique case (cmd)
      CMD_POP: begin
        result[PRI_W-1:0]             = head_entry.pri;
        result[PRI_W+STAMP_W-1:PRI_W] = head_entry.stamp;
      end
      CMD_CHECK: result[PRI_W+STAMP_W] = overdue;
      CMD_PUSH:  ;
      default:   ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      limit_r     <= STALE_LIMIT_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/tlspq_cell.sv
module tlspq_cell
  import tlspq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cell_op_t op,
  input  slot_t    left,
  input  slot_t    right,
  output slot_t    slot
);

  slot_t slot_r;
  slot_t slot_nxt;

  // The queue stays sorted by priority with all empty slots at the tail, so
  // the insertion point is found by comparing this slot with its left neighbor.
  always_comb begin
    slot_nxt = slot_r;
    if (op.pop) begin
      slot_nxt = right;
    end else if (op.push_high) begin
      slot_nxt = left;
    end else if (op.push_mid) begin
      if (slot_r.pri < PRI_MID) begin
        if (left.pri >= PRI_MID) begin
          slot_nxt.pri   = PRI_MID;
          slot_nxt.stamp = op.stamp;
        end else begin
          slot_nxt = left;
        end
      end
    end else if (op.push_low) begin
      if ((slot_r.pri == PRI_EMPTY) && (left.pri != PRI_EMPTY)) begin
        slot_nxt.pri   = PRI_LOW;
        slot_nxt.stamp = op.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot = slot_r;

endmodule

>>> rtl/tlspq_checker.sv
module tlspq_checker
  import tlspq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [CMD_W-1:0]      in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted transaction produced no result");

  a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_PUSH)) |=> (out_tdata == '0))
    else $error("push result is not all zero");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind three_level_shift_priority_queue_unit tlspq_checker u_tlspq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
